>>> src/pgsc_pkg.sv
// shared types and constants for the pcm widen, gain and soft clip block
package pgsc_pkg;

   // port widths fixed by the sample and register formats
   localparam int SAMPLE_W    = 32;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // sample_format codes
   localparam logic [1:0] FMT_16 = 2'd0;
   localparam logic [1:0] FMT_24 = 2'd1;
   localparam logic [1:0] FMT_32 = 2'd2;

   // clip_region codes
   localparam logic [1:0] REGION_LINEAR = 2'd0;
   localparam logic [1:0] REGION_KNEE   = 2'd1;
   localparam logic [1:0] REGION_CLIP   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_FORMAT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN          = 4'd1;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

   // knee constants in units of 2^-31
   localparam logic [30:0] K_START  = 31'd1503238554;   // 0.7
   localparam logic [30:0] K_THRESH = 31'd1717986918;   // 0.8
   localparam logic [30:0] K_END    = 31'd1932735283;   // 0.9
   localparam logic [28:0] K_WIDTH  = 29'd429496730;    // 0.2
   localparam logic [30:0] Q_HALF   = 31'h4000_0000;
   localparam logic [31:0] Q_ONE    = 32'h8000_0000;

   // tanh argument: |u| with saturation and sign of u
   typedef struct packed {
      logic [33:0] u_mag;
      logic        u_sat;
      logic        u_neg;
   } pgsc_targ_type;

   // per-sample data that rides alongside the tanh lookup
   typedef struct packed {
      logic signed [31:0] g;
      logic               g_neg;
      logic [1:0]         region;
      logic [30:0]        t;
   } pgsc_side_type;

endpackage

>>> src/pgsc_front.sv
// front end: widen, gain multiply, magnitude and region classification
module pgsc_front #(
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [pgsc_pkg::SAMPLE_W-1:0] raw_sample,
   input  logic [1:0]                    sample_format,
   input  logic [pgsc_pkg::GAIN_W-1:0]   gain,
   output logic                          out_valid,
   output pgsc_pkg::pgsc_targ_type       out_targ,
   output pgsc_pkg::pgsc_side_type       out_side
);

   localparam int PROD_W = pgsc_pkg::SAMPLE_W + pgsc_pkg::GAIN_W + 1;
   localparam int GW     = PROD_W - GAIN_FRAC_BITS;
   localparam int UW     = GW + 3;

   logic                     x_valid_in, x_valid_ff;
   logic signed [31:0]       x_in, x_ff;
   logic                     p_valid_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic                     a_valid_ff;
   logic signed [GW-1:0]     g_in, g_ff;
   logic [GW-1:0]            a_in, a_ff;
   logic                     c_valid_ff;
   logic                     above;
   logic [GW-1:0]            dabs;
   logic [UW-1:0]            uabs;
   logic [31:0]              kd;
   pgsc_pkg::pgsc_targ_type  targ_in, targ_ff;
   pgsc_pkg::pgsc_side_type  side_in, side_ff;

   // left-align the sample; the unused format code drops the beat
   always_comb begin
      x_valid_in = in_valid;
      case (sample_format)
         pgsc_pkg::FMT_16: x_in = {raw_sample[15:0], 16'h0000};
         pgsc_pkg::FMT_24: x_in = {raw_sample[23:0], 8'h00};
         pgsc_pkg::FMT_32: x_in = raw_sample;
         default: begin
            x_in       = raw_sample;
            x_valid_in = 1'b0;
         end
      endcase
   end

   // gain multiply, signed sample by unsigned gain
   assign prod_in = PROD_W'(x_ff) * PROD_W'($signed({1'b0, gain}));

   // floor shift by the gain fraction and magnitude
   assign g_in = prod_ff[PROD_W-1:GAIN_FRAC_BITS];
   assign a_in = g_in[GW-1] ? GW'(-g_in) : GW'(g_in);

   // region, tanh argument |a - 0.8| * 5 and knee position (a - 0.7) * 5
   always_comb begin
      above = a_ff >= GW'(pgsc_pkg::K_THRESH);
      dabs  = above ? a_ff - GW'(pgsc_pkg::K_THRESH) : GW'(pgsc_pkg::K_THRESH) - a_ff;
      uabs  = UW'(dabs) + UW'({dabs, 2'b00});
      kd    = a_ff[31:0] - 32'(pgsc_pkg::K_START);

      targ_in.u_mag = uabs[33:0];
      targ_in.u_sat = |uabs[UW-1:34];
      targ_in.u_neg = !above;

      side_in.g     = g_ff[31:0];
      side_in.g_neg = g_ff[GW-1];
      side_in.t     = kd[30:0] + {kd[28:0], 2'b00};
      if (a_ff <= GW'(pgsc_pkg::K_START)) begin
         side_in.region = pgsc_pkg::REGION_LINEAR;
      end else if (a_ff >= GW'(pgsc_pkg::K_END)) begin
         side_in.region = pgsc_pkg::REGION_CLIP;
      end else begin
         side_in.region = pgsc_pkg::REGION_KNEE;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= x_valid_in;
         p_valid_ff <= x_valid_ff;
         a_valid_ff <= p_valid_ff;
         c_valid_ff <= a_valid_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
      g_ff    <= g_in;
      a_ff    <= a_in;
      targ_ff <= targ_in;
      side_ff <= side_in;
   end

   assign out_valid = c_valid_ff;
   assign out_targ  = targ_ff;
   assign out_side  = side_ff;

endmodule

>>> src/pgsc_tanh.sv
// tanh lookup: table index, table read and linear interpolation
module pgsc_tanh #(
   parameter int TANH_TABLE_DEPTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  pgsc_pkg::pgsc_targ_type in_targ,
   input  pgsc_pkg::pgsc_side_type in_side,
   output logic                    out_valid,
   output logic [31:0]             out_mag,
   output logic                    out_neg,
   output pgsc_pkg::pgsc_side_type out_side
);

   localparam int IW = $clog2(TANH_TABLE_DEPTH + 1);
   localparam int MW = 34 + IW;

   logic [31:0] rom_table [0:TANH_TABLE_DEPTH];

   // entry i holds tanh(8 * i / depth) in units of 2^-31, built at elaboration:
   // e^-w by a short series, raised to the 32nd power to reach e^-2x with
   // x = 8 * i / depth, then (1 - z) / (1 + z)
   for (genvar gi = 0; gi <= TANH_TABLE_DEPTH; gi++) begin : g_rom
      localparam logic [63:0] W   = (64'(gi) << 30) / 64'(TANH_TABLE_DEPTH);
      localparam logic [63:0] T1  = ((64'h8000_0000 * W) >> 31) / 64'd1;
      localparam logic [63:0] T2  = ((T1 * W) >> 31) / 64'd2;
      localparam logic [63:0] T3  = ((T2 * W) >> 31) / 64'd3;
      localparam logic [63:0] T4  = ((T3 * W) >> 31) / 64'd4;
      localparam logic [63:0] T5  = ((T4 * W) >> 31) / 64'd5;
      localparam logic [63:0] T6  = ((T5 * W) >> 31) / 64'd6;
      localparam logic [63:0] T7  = ((T6 * W) >> 31) / 64'd7;
      localparam logic [63:0] T8  = ((T7 * W) >> 31) / 64'd8;
      localparam logic [63:0] T9  = ((T8 * W) >> 31) / 64'd9;
      localparam logic [63:0] T10 = ((T9 * W) >> 31) / 64'd10;
      localparam logic [63:0] T11 = ((T10 * W) >> 31) / 64'd11;
      localparam logic [63:0] T12 = ((T11 * W) >> 31) / 64'd12;
      localparam logic [63:0] T13 = ((T12 * W) >> 31) / 64'd13;
      localparam logic [63:0] T14 = ((T13 * W) >> 31) / 64'd14;
      localparam logic signed [63:0] SUM = 64'sh8000_0000
         - $signed(T1) + $signed(T2) - $signed(T3) + $signed(T4)
         - $signed(T5) + $signed(T6) - $signed(T7) + $signed(T8)
         - $signed(T9) + $signed(T10) - $signed(T11) + $signed(T12)
         - $signed(T13) + $signed(T14);
      localparam logic [63:0] Z0 = (SUM < 0) ? 64'd0 : 64'(SUM);
      localparam logic [63:0] Z1 = (Z0 * Z0 + 64'h4000_0000) >> 31;
      localparam logic [63:0] Z2 = (Z1 * Z1 + 64'h4000_0000) >> 31;
      localparam logic [63:0] Z3 = (Z2 * Z2 + 64'h4000_0000) >> 31;
      localparam logic [63:0] Z4 = (Z3 * Z3 + 64'h4000_0000) >> 31;
      localparam logic [63:0] Z5 = (Z4 * Z4 + 64'h4000_0000) >> 31;
      localparam logic [63:0] ZC = (Z5 > 64'h8000_0000) ? 64'h8000_0000 : Z5;
      localparam logic [31:0] ENTRY_VALUE =
         32'(((64'h8000_0000 - ZC) << 31) / (64'h8000_0000 + ZC));
      assign rom_table[gi] = ENTRY_VALUE;
   end

   logic                    v1_ff, v2_ff, v3_ff;
   logic [MW-1:0]           m;
   logic [IW-1:0]           idx_in, idx_ff, idx_next;
   logic [30:0]             frac_in, frac1_ff, frac2_ff;
   logic                    sat1_ff, sat2_ff;
   logic                    neg1_ff, neg2_ff, neg3_ff;
   pgsc_pkg::pgsc_side_type side1_ff, side2_ff, side3_ff;
   logic [31:0]             lo_ff, hi_ff;
   logic signed [32:0]      d;
   logic signed [63:0]      dp;
   logic signed [32:0]      dsh;
   logic signed [33:0]      r;
   logic [31:0]             mag_in, mag_ff;

   // scale |u| by the table depth: integer part indexes, the rest interpolates
   assign m       = MW'(in_targ.u_mag) * MW'(TANH_TABLE_DEPTH);
   assign idx_in  = m[34 +: IW];
   assign frac_in = m[33:3];

   assign idx_next = idx_ff + IW'(1);

   // interpolate between neighbors, clamp to 0..1, saturate past the table
   always_comb begin
      d   = $signed({1'b0, hi_ff}) - $signed({1'b0, lo_ff});
      dp  = 64'(d) * 64'($signed({1'b0, frac2_ff}));
      dsh = dp[63:31];
      r   = $signed({2'b00, lo_ff}) + 34'(dsh);
      if (sat2_ff) begin
         mag_in = pgsc_pkg::Q_ONE;
      end else if (r < 0) begin
         mag_in = 32'h0;
      end else if (r > $signed({2'b00, pgsc_pkg::Q_ONE})) begin
         mag_in = pgsc_pkg::Q_ONE;
      end else begin
         mag_in = r[31:0];
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage payload, table read registered
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      frac1_ff <= frac_in;
      sat1_ff  <= in_targ.u_sat;
      neg1_ff  <= in_targ.u_neg;
      side1_ff <= in_side;

      lo_ff    <= rom_table[idx_ff];
      hi_ff    <= rom_table[idx_next];
      frac2_ff <= frac1_ff;
      sat2_ff  <= sat1_ff;
      neg2_ff  <= neg1_ff;
      side2_ff <= side1_ff;

      mag_ff   <= mag_in;
      neg3_ff  <= neg2_ff;
      side3_ff <= side2_ff;
   end

   assign out_valid = v3_ff;
   assign out_mag   = mag_ff;
   assign out_neg   = neg3_ff;
   assign out_side  = side3_ff;

endmodule

>>> src/pgsc_blend.sv
// clipped level, smoothstep weight, knee blend and output saturation
module pgsc_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [31:0]             in_mag,
   input  logic                    in_neg,
   input  pgsc_pkg::pgsc_side_type in_side,
   output logic                    out_strobe,
   output logic signed [31:0]      out_sample,
   output logic [1:0]              out_region
);

   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   pgsc_pkg::pgsc_side_type side1_ff, side2_ff, side3_ff;
   logic signed [32:0]      th;
   logic signed [63:0]      cp;
   logic signed [32:0]      csh;
   logic signed [33:0]      c_mag;
   logic signed [33:0]      c_in, c1_ff, c2_ff, c3_ff;
   logic [61:0]             tt;
   logic [30:0]             t2_in, t2_ff;
   logic [32:0]             s;
   logic [63:0]             wp;
   logic [32:0]             wgt_in, wgt_ff;
   logic signed [33:0]      diff_in, diff_ff;
   logic signed [67:0]      kp_in, kp_ff;
   logic signed [67:0]      kr;
   logic signed [36:0]      ksh;
   logic signed [37:0]      res_k, res;
   logic signed [31:0]      sample_in, sample_ff;
   logic [1:0]              region_ff;

   // clipped magnitude 0.8 + 0.2 * tanh, rounded, then the sign of g
   always_comb begin
      th    = in_neg ? -$signed({1'b0, in_mag}) : $signed({1'b0, in_mag});
      cp    = 64'(th) * 64'($signed({1'b0, pgsc_pkg::K_WIDTH}))
              + $signed(64'(pgsc_pkg::Q_HALF));
      csh   = cp[63:31];
      c_mag = $signed(34'(pgsc_pkg::K_THRESH)) + 34'(csh);
      c_in  = in_side.g_neg ? -c_mag : c_mag;
   end

   // t squared
   assign tt    = 62'(in_side.t) * 62'(in_side.t);
   assign t2_in = tt[61:31];

   // smoothstep weight t^2 * (3 - 2t) and the distance to the clipped level
   assign s       = 33'h1_8000_0000 - {1'b0, side1_ff.t, 1'b0};
   assign wp      = 64'(t2_ff) * 64'(s);
   assign wgt_in  = wp[63:31];
   assign diff_in = c1_ff - 34'(side1_ff.g);

   // weighted step toward the clipped level
   assign kp_in = 68'($signed({1'b0, wgt_ff})) * 68'(diff_ff);

   // pick the region result and saturate to 32 bits
   always_comb begin
      kr    = kp_ff + $signed(68'(pgsc_pkg::Q_HALF));
      ksh   = kr[67:31];
      res_k = 38'(side3_ff.g) + 38'(ksh);
      case (side3_ff.region)
         pgsc_pkg::REGION_LINEAR: res = 38'(side3_ff.g);
         pgsc_pkg::REGION_KNEE:   res = res_k;
         pgsc_pkg::REGION_CLIP:   res = 38'(c3_ff);
         default:                 res = 38'(side3_ff.g);
      endcase
      if (res > 38'sd2147483647) begin
         sample_in = 32'sh7FFF_FFFF;
      end else if (res < -38'sd2147483648) begin
         sample_in = 32'sh8000_0000;
      end else begin
         sample_in = res[31:0];
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      c1_ff     <= c_in;
      t2_ff     <= t2_in;
      side1_ff  <= in_side;

      c2_ff     <= c1_ff;
      wgt_ff    <= wgt_in;
      diff_ff   <= diff_in;
      side2_ff  <= side1_ff;

      c3_ff     <= c2_ff;
      kp_ff     <= kp_in;
      side3_ff  <= side2_ff;

      sample_ff <= sample_in;
      region_ff <= side3_ff.region;
   end

   assign out_strobe = v4_ff;
   assign out_sample = sample_ff;
   assign out_region = region_ff;

endmodule

>>> src/pcm_widen_gain_soft_clip.sv
// top level of the pcm widen, gain and soft clip block
// Takes one sample beat per clock: busy never rises, and each result leaves on
// rsp_strobe for a single cycle, with no way for the receiver to hold it. The
// pipeline runs, in order, through sample widening, gain multiply, magnitude,
// classification, table index multiply, registered tanh table read,
// interpolation multiply, clip level multiply, smoothstep multiply, blend
// multiply and output saturation, each taking one register stage. A beat taken
// while sample_format is 3 gives no result. The tanh table holds
// TANH_TABLE_DEPTH + 1 constant entries worked out at elaboration, so there is
// no start-up pass. csr_ready is always high; registers should be written
// only while no beats are in flight.
module pcm_widen_gain_soft_clip #(
   parameter int TANH_TABLE_DEPTH = 1024,
   parameter int GAIN_FRAC_BITS   = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [pgsc_pkg::SAMPLE_W-1:0]    req_raw_sample,
   output logic                             rsp_strobe,
   output logic signed [31:0]               rsp_out_sample,
   output logic [1:0]                       rsp_clip_region,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pgsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pgsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [1:0]                    sample_format_in, sample_format_ff;
   logic [pgsc_pkg::GAIN_W-1:0]   gain_in, gain_ff;
   logic                          front_valid;
   pgsc_pkg::pgsc_targ_type       front_targ;
   pgsc_pkg::pgsc_side_type       front_side;
   logic                          tanh_valid;
   logic [31:0]                   tanh_mag;
   logic                          tanh_neg;
   pgsc_pkg::pgsc_side_type       tanh_side;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // register writes, unknown indexes ignored
   always_comb begin
      sample_format_in = sample_format_ff;
      gain_in          = gain_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pgsc_pkg::CSR_SAMPLE_FORMAT: sample_format_in = csr_wdata[1:0];
            pgsc_pkg::CSR_GAIN:          gain_in          = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= pgsc_pkg::FMT_16;
         gain_ff          <= pgsc_pkg::GAIN_RESET;
      end else begin
         sample_format_ff <= sample_format_in;
         gain_ff          <= gain_in;
      end
   end

   pgsc_front #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start && !busy),
      .raw_sample    (req_raw_sample),
      .sample_format (sample_format_ff),
      .gain          (gain_ff),
      .out_valid     (front_valid),
      .out_targ      (front_targ),
      .out_side      (front_side)
   );

   pgsc_tanh #(
      .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
   ) u_tanh (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_targ   (front_targ),
      .in_side   (front_side),
      .out_valid (tanh_valid),
      .out_mag   (tanh_mag),
      .out_neg   (tanh_neg),
      .out_side  (tanh_side)
   );

   pgsc_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (tanh_valid),
      .in_mag     (tanh_mag),
      .in_neg     (tanh_neg),
      .in_side    (tanh_side),
      .out_strobe (rsp_strobe),
      .out_sample (rsp_out_sample),
      .out_region (rsp_clip_region)
   );

endmodule

>>> src/pgsc_checker.sv
// port-level checks for the pcm widen, gain and soft clip block, with its bind
module pgsc_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_out_sample,
   input logic [1:0]         rsp_clip_region
);

   localparam int PIPE_LATENCY = 11;

   // every result traces back to a beat taken at the input
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without a beat taken at the pipeline latency");

   // only the three region codes appear
   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_clip_region == pgsc_pkg::REGION_LINEAR ||
                      rsp_clip_region == pgsc_pkg::REGION_KNEE ||
                      rsp_clip_region == pgsc_pkg::REGION_CLIP))
      else $error("unknown clip region code");

   // a linear pass stays within the knee start
   a_linear_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_clip_region == pgsc_pkg::REGION_LINEAR) |->
      (rsp_out_sample <= $signed(32'(pgsc_pkg::K_START)) &&
       rsp_out_sample >= -$signed(32'(pgsc_pkg::K_START))))
      else $error("linear result beyond the knee start");

   // a full clip never falls below the threshold level
   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_clip_region == pgsc_pkg::REGION_CLIP) |->
      (rsp_out_sample >= $signed(32'(pgsc_pkg::K_THRESH)) ||
       rsp_out_sample <= -$signed(32'(pgsc_pkg::K_THRESH))))
      else $error("clipped result inside the threshold");

endmodule

bind pcm_widen_gain_soft_clip pgsc_checker u_pgsc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_out_sample  (rsp_out_sample),
   .rsp_clip_region (rsp_clip_region)
);
